// File: src/ntsc_pkg.sv
// ============================================================================
// ntsc_pkg
// Shared types, constants, font and control program for the decimal number
// to scrolling display column renderer.
// ============================================================================
package ntsc_pkg;

    // Strip and window geometry.
    localparam int MaxDigits   = 5;
    localparam int ViewCols    = 5;
    localparam int LastStripCol = 19;

    // Field widths of the channels.
    localparam int ValueW  = 16;
    localparam int OffsetW = 8;
    localparam int IndexW  = 3;
    localparam int PatW    = 7;
    localparam int CountW  = 3;

    // Program counter width and the entry points of the control program.
    localparam int PcW = 4;
    localparam logic [PcW-1:0] PC_IDLE  = 4'd0;
    localparam logic [PcW-1:0] PC_DIV0  = 4'd1;
    localparam logic [PcW-1:0] PC_EMIT0 = 4'd6;

    // Reciprocal of ten, scaled by two to the power of 19, exact for 16-bit values.
    localparam logic [32:0] RecipTen = 33'd52429;
    localparam int          RecipShift = 19;

    // Datapath operation of one step.
    typedef enum logic [1:0] {
        OP_IDLE,
        OP_DIV,
        OP_EMIT
    } t_op;

    // Sequencing condition of one step.
    typedef enum logic [1:0] {
        CD_WAIT_IN,
        CD_IF_ZERO,
        CD_WAIT_OUT,
        CD_WAIT_OUT_END
    } t_cond;

    // One control word.
    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [IndexW-1:0] col;
        logic [PcW-1:0]   target;
    } t_uop;

    // Status returned from the datapath to the sequencer.
    typedef struct packed {
        logic in_beat;
        logic val_zero;
        logic out_free;
    } t_stat;

    // Three glyph columns for each decimal digit, bit 0 is the top row.
    localparam logic [PatW-1:0] FONT [10][3] = '{
        '{7'h3e, 7'h22, 7'h3e},
        '{7'h24, 7'h3e, 7'h20},
        '{7'h3a, 7'h2a, 7'h2e},
        '{7'h2a, 7'h2a, 7'h3e},
        '{7'h0e, 7'h08, 7'h3e},
        '{7'h2e, 7'h2a, 7'h3a},
        '{7'h3e, 7'h2a, 7'h3a},
        '{7'h02, 7'h02, 7'h3e},
        '{7'h3e, 7'h2a, 7'h3e},
        '{7'h0e, 7'h0a, 7'h3e}
    };

    // Column of a digit cell: phase zero is the blank spacer column.
    function automatic logic [PatW-1:0] font_col(input logic [3:0] digit,
                                                 input logic [1:0] phase);
        logic [1:0]      glyph_col;
        logic [PatW-1:0] pat;
        glyph_col = phase - 2'd1;
        pat       = '0;
        if (digit <= 4'd9 && phase != 2'd0) begin
            pat = FONT[digit][glyph_col];
        end
        return pat;
    endfunction

    // Control program: accept, up to five divide steps, five emit steps.
    function automatic t_uop ntsc_rom(input logic [PcW-1:0] pc);
        t_uop w;
        w = '{op: OP_IDLE, cond: CD_WAIT_IN, col: 3'd0, target: PC_IDLE};
        unique case (pc)
            4'd0: w = '{op: OP_IDLE, cond: CD_WAIT_IN,  col: 3'd0, target: PC_DIV0};
            4'd1: w = '{op: OP_DIV,  cond: CD_IF_ZERO,  col: 3'd0, target: PC_EMIT0};
            4'd2: w = '{op: OP_DIV,  cond: CD_IF_ZERO,  col: 3'd0, target: PC_EMIT0};
            4'd3: w = '{op: OP_DIV,  cond: CD_IF_ZERO,  col: 3'd0, target: PC_EMIT0};
            4'd4: w = '{op: OP_DIV,  cond: CD_IF_ZERO,  col: 3'd0, target: PC_EMIT0};
            4'd5: w = '{op: OP_DIV,  cond: CD_IF_ZERO,  col: 3'd0, target: PC_EMIT0};
            4'd6: w = '{op: OP_EMIT, cond: CD_WAIT_OUT, col: 3'd0, target: PC_IDLE};
            4'd7: w = '{op: OP_EMIT, cond: CD_WAIT_OUT, col: 3'd1, target: PC_IDLE};
            4'd8: w = '{op: OP_EMIT, cond: CD_WAIT_OUT, col: 3'd2, target: PC_IDLE};
            4'd9: w = '{op: OP_EMIT, cond: CD_WAIT_OUT, col: 3'd3, target: PC_IDLE};
            4'd10: w = '{op: OP_EMIT, cond: CD_WAIT_OUT_END, col: 3'd4, target: PC_IDLE};
            default: w = '{op: OP_IDLE, cond: CD_IF_ZERO, col: 3'd0, target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: src/ntsc_if.sv
// ============================================================================
// ntsc_if
// Valid/ready channels: the number input and the display column output.
// ============================================================================
interface ntsc_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        value;
    logic signed [7:0]  scroll_offset;

    modport source (output valid, output value, output scroll_offset, input ready);
    modport sink   (input valid, input value, input scroll_offset, output ready);
endinterface

interface ntsc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] column_index;
    logic [6:0] column_pattern;
    logic [2:0] digit_count;
    logic       last;

    modport source (output valid, output column_index, output column_pattern,
                    output digit_count, output last, input ready);
    modport sink   (input valid, input column_index, input column_pattern,
                    input digit_count, input last, output ready);
endinterface

// File: src/number_to_scroll_columns.sv
// ============================================================================
// number_to_scroll_columns
// Renders a 16-bit value as decimal digits into a 20-column strip and sends
// the five display columns seen at a signed scroll offset.
// ============================================================================
//  Channel  Dir  Beat carries
//  i_in     in   value[15:0], scroll_offset[7:0] signed
//  o_out    out  column_index[2:0], column_pattern[6:0], digit_count[2:0], last
//
//  Each item runs one accept step, then one divide-by-ten step per digit
//  plus a final zero test when there are fewer than five digits (at most
//  five steps), then five column steps. Divide steps use the shared divide
//  unit; each column step waits while the output beat is not taken.
//  Reset is synchronous and active low and returns the program to its
//  accept step with the output register empty.
// ============================================================================
module number_to_scroll_columns (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntsc_in_if.sink     i_in,
    ntsc_out_if.source  o_out
);
    import ntsc_pkg::*;

    t_uop  uop;
    t_stat stat;

    // Control program sequencer.
    ntsc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uop   (uop)
    );

    // Datapath.
    ntsc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uop   (uop),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// File: src/ntsc_seq.sv
// ============================================================================
// ntsc_seq
// Step counter and control program store; issues one control word a cycle.
// ============================================================================
module ntsc_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ntsc_pkg::t_stat i_stat,
    output ntsc_pkg::t_uop  o_uop
);
    import ntsc_pkg::*;

    logic [PcW-1:0] r_pc;
    logic [PcW-1:0] n_pc;
    t_uop           uop;

    // Fetch the control word of the current step.
    assign uop   = ntsc_rom(r_pc);
    assign o_uop = uop;

    // Next step: fall through, hold while waiting, or jump.
    always_comb begin
        n_pc = r_pc + 4'd1;
        unique case (uop.cond)
            CD_WAIT_IN: begin
                if (!i_stat.in_beat) n_pc = r_pc;
            end
            CD_IF_ZERO: begin
                if (i_stat.val_zero) n_pc = uop.target;
            end
            CD_WAIT_OUT: begin
                if (!i_stat.out_free) n_pc = r_pc;
            end
            CD_WAIT_OUT_END: begin
                n_pc = i_stat.out_free ? uop.target : r_pc;
            end
            default: n_pc = PC_IDLE;
        endcase
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: src/ntsc_datapath.sv
// ============================================================================
// ntsc_datapath
// Value register, divide-by-ten unit, digit slots, column render and the
// output register, all steered by the current control word.
// ============================================================================
module ntsc_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ntsc_pkg::t_uop  i_uop,
    output ntsc_pkg::t_stat o_stat,
    ntsc_in_if.sink         i_in,
    ntsc_out_if.source      o_out
);
    import ntsc_pkg::*;

    logic [ValueW-1:0]  r_val;
    logic signed [OffsetW-1:0] r_off;
    logic [CountW-1:0]  r_ndig;
    logic [3:0]         r_digs [MaxDigits];

    logic               r_out_valid;
    logic [IndexW-1:0]  r_out_index;
    logic [PatW-1:0]    r_out_pat;
    logic [CountW-1:0]  r_out_count;
    logic               r_out_last;

    logic               in_beat;
    logic               out_free;
    logic               val_zero;

    logic [32:0]        prod;
    logic [12:0]        quot;
    logic [ValueW-1:0]  quot10;
    logic [ValueW-1:0]  rem;
    logic [2:0]         slot_wr;

    logic signed [OffsetW:0] col;
    logic [2:0]         slot_rd;
    logic [1:0]         phase;
    logic [3:0]         fill_sum;
    logic               col_in_strip;
    logic [PatW-1:0]    pat;

    // Handshake and status.
    assign i_in.ready = (i_uop.op == OP_IDLE);
    assign in_beat    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign val_zero   = (r_val == '0);
    assign o_stat     = '{in_beat: in_beat, val_zero: val_zero, out_free: out_free};

    // Divide by ten through the scaled reciprocal; remainder by back-multiply.
    always_comb begin
        prod    = {17'd0, r_val} * RecipTen;
        quot    = prod[RecipShift+12:RecipShift];
        quot10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
        rem     = r_val - quot10;
        slot_wr = 3'(MaxDigits - 1) - r_ndig;
    end

    // Strip column for the current window position and its pattern.
    always_comb begin
        col          = {r_off[OffsetW-1], r_off} + $signed({6'd0, i_uop.col});
        col_in_strip = (col >= 0) && (col <= $signed(9'(LastStripCol)));
        slot_rd      = col[4:2];
        phase        = col[1:0];
        fill_sum     = {1'b0, slot_rd} + {1'b0, r_ndig};
        pat          = '0;
        if (col_in_strip && fill_sum >= 4'(MaxDigits)) begin
            pat = font_col(r_digs[slot_rd], phase);
        end
    end

    // Value, offset, digit count and digit slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndig <= '0;
        end else begin
            if (in_beat) begin
                r_val  <= i_in.value;
                r_off  <= i_in.scroll_offset;
                r_ndig <= '0;
            end else if (i_uop.op == OP_DIV && !val_zero) begin
                r_val            <= {3'b000, quot};
                r_digs[slot_wr]  <= rem[3:0];
                r_ndig           <= r_ndig + 3'd1;
            end
        end
    end

    // Output register: loads a column beat on an emit step when the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_uop.op == OP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_out_index <= i_uop.col;
                r_out_pat   <= pat;
                r_out_count <= r_ndig;
                r_out_last  <= (i_uop.col == 3'(ViewCols - 1));
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.column_index   = r_out_index;
    assign o_out.column_pattern = r_out_pat;
    assign o_out.digit_count    = r_out_count;
    assign o_out.last           = r_out_last;

endmodule

// File: src/ntsc_checker.sv
// ============================================================================
// ntsc_checker
// Port-level checks on the column renderer, bound to the top level.
// ============================================================================
module ntsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_index,
    input logic [6:0] i_out_pattern,
    input logic [2:0] i_out_count,
    input logic       i_out_last
);

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_index) && $stable(i_out_pattern)
            && $stable(i_out_count) && $stable(i_out_last))
        else $error("output beat changed while stalled");

    // Work on one item blocks the input in the following cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted on consecutive cycles");

    // The last flag marks exactly the fifth column.
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == 3'd4)))
        else $error("last flag does not match column index");

    // Column index and digit count stay in range.
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_index <= 3'd4) && (i_out_count <= 3'd5))
        else $error("column index or digit count out of range");

endmodule

bind number_to_scroll_columns ntsc_checker u_ntsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_index   (o_out.column_index),
    .i_out_pattern (o_out.column_pattern),
    .i_out_count   (o_out.digit_count),
    .i_out_last    (o_out.last)
);
